// ===== hdl/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// Call/return tracker package
// Shared widths, codes and payload types of the call/return tracker.
// ----------------------------------------------------------------------------
package crt_pkg;

   localparam int ADDR_W  = 32;
   localparam int SLOT_W  = 3;
   localparam int EVENT_W = 2;
   localparam int COUNT_W = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Action codes of an input item.
   localparam logic ACTION_EXECUTE  = 1'b0;
   localparam logic ACTION_REGISTER = 1'b1;

   // Event codes of a result item.
   localparam logic [EVENT_W-1:0] EVENT_NONE  = 2'd0;
   localparam logic [EVENT_W-1:0] EVENT_ENTER = 2'd1;
   localparam logic [EVENT_W-1:0] EVENT_LEAVE = 2'd2;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] return_address;
      logic [SLOT_W-1:0] function_slot;
   } req_type;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [SLOT_W-1:0]  matched_function;
      logic               recursive;
      logic               table_full;
   } rsp_type;

endpackage

// ===== hdl/crt_channels.sv =====
// ----------------------------------------------------------------------------
// Call/return tracker channels
// Valid/ready interfaces for the request and response channels.
// ----------------------------------------------------------------------------
interface crt_req_if;
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic [crt_pkg::ADDR_W-1:0] address;
   logic [crt_pkg::ADDR_W-1:0] return_address;
   logic [crt_pkg::SLOT_W-1:0] function_slot;

   modport source (output valid, action, address, return_address, function_slot,
                   input ready);
   modport sink   (input valid, action, address, return_address, function_slot,
                   output ready);
endinterface

interface crt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [crt_pkg::EVENT_W-1:0] event_res;
   logic [crt_pkg::SLOT_W-1:0]  matched_function;
   logic                        recursive;
   logic                        table_full;

   modport source (output valid, event_res, matched_function, recursive, table_full,
                   input ready);
   modport sink   (input valid, event_res, matched_function, recursive, table_full,
                   output ready);
endinterface

// ===== hdl/crt_lowest.sv =====
// ----------------------------------------------------------------------------
// Lowest set bit encoder
// Reports whether any bit is set and the index of the lowest one.
// ----------------------------------------------------------------------------
module crt_lowest #(
   parameter int WIDTH = 16
) (
   input  logic [WIDTH-1:0]         bits,
   output logic                     found,
   output logic [$clog2(WIDTH)-1:0] index
);
   localparam int IDX_W = $clog2(WIDTH);

   // Scan from the top so that the lowest set bit wins.
   always_comb begin
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (bits[i]) begin
            index = IDX_W'(i);
         end
      end
      found = |bits;
   end
endmodule

// ===== hdl/crt_table.sv =====
// ----------------------------------------------------------------------------
// Call/return record table
// Associative record table with the function active marks; looks up one
// item, forms its result and applies its single record update per fired cycle.
// ----------------------------------------------------------------------------
module crt_table #(
   parameter int TABLE_ENTRIES  = 16,
   parameter int FUNCTION_SLOTS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  crt_pkg::req_type item,
   output crt_pkg::rsp_type result
);
   import crt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int FN_W  = (FUNCTION_SLOTS > 1) ? $clog2(FUNCTION_SLOTS) : 1;

   // Record store: valid and kind bits are reset, the rest is payload.
   logic [TABLE_ENTRIES-1:0]  valid_ff;
   logic [TABLE_ENTRIES-1:0]  is_ret_ff;
   logic [ADDR_W-1:0]         addr_ff  [TABLE_ENTRIES];
   logic [FN_W-1:0]           fn_ff    [TABLE_ENTRIES];
   logic [COUNT_W-1:0]        count_ff [TABLE_ENTRIES];
   logic [FUNCTION_SLOTS-1:0] active_ff;

   logic [TABLE_ENTRIES-1:0] match_a;
   logic [TABLE_ENTRIES-1:0] match_r;
   logic                     hit_a;
   logic                     hit_r;
   logic                     any_free;
   logic [IDX_W-1:0]         idx_a;
   logic [IDX_W-1:0]         idx_r;
   logic [IDX_W-1:0]         free_idx;

   logic [FN_W-1:0]    f_sel;
   logic               ret_sel;
   logic [IDX_W-1:0]   rd_idx;
   logic [COUNT_W-1:0] cnt_rd;
   logic [FN_W+2:0]    f_ext;

   logic               rec_we;
   logic               wr_key;
   logic [IDX_W-1:0]   wr_idx;
   logic               valid_in;
   logic               is_ret_in;
   logic [ADDR_W-1:0]  addr_in;
   logic [FN_W-1:0]    fn_in;
   logic [COUNT_W-1:0] count_in;
   logic               act_we;
   logic [FN_W-1:0]    act_idx;
   logic               act_in;

   // Wraps a function slot into the configured number of slots.
   function automatic logic [FN_W-1:0] wrap_slot(input logic [SLOT_W-1:0] s);
      logic [7:0] v;
      v = 8'(s);
      for (int k = 0; k < 8; k++) begin
         if (v >= 8'(FUNCTION_SLOTS)) begin
            v = v - 8'(FUNCTION_SLOTS);
         end
      end
      return FN_W'(v);
   endfunction

   // Parallel compare of both lookup keys against every valid record.
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match_a[i] = valid_ff[i] && (addr_ff[i] == item.address);
         match_r[i] = valid_ff[i] && (addr_ff[i] == item.return_address);
      end
   end

   crt_lowest #(.WIDTH(TABLE_ENTRIES)) u_hit_addr (
      .bits  (match_a),
      .found (hit_a),
      .index (idx_a)
   );

   crt_lowest #(.WIDTH(TABLE_ENTRIES)) u_hit_ret (
      .bits  (match_r),
      .found (hit_r),
      .index (idx_r)
   );

   crt_lowest #(.WIDTH(TABLE_ENTRIES)) u_free (
      .bits  (~valid_ff),
      .found (any_free),
      .index (free_idx)
   );

   // Fields of the address-lookup hit and the count of the record to update.
   assign f_sel   = fn_ff[idx_a];
   assign ret_sel = is_ret_ff[idx_a];
   assign rd_idx  = ret_sel ? idx_a : idx_r;
   assign cnt_rd  = count_ff[rd_idx];
   assign f_ext   = (FN_W + 3)'(f_sel);

   // Result and the one record update that the item causes.
   always_comb begin
      result    = '0;
      rec_we    = 1'b0;
      wr_key    = 1'b0;
      wr_idx    = free_idx;
      valid_in  = 1'b1;
      is_ret_in = 1'b0;
      addr_in   = item.address;
      fn_in     = wrap_slot(item.function_slot);
      count_in  = '0;
      act_we    = 1'b0;
      act_idx   = f_sel;
      act_in    = 1'b0;
      case (item.action)
         ACTION_REGISTER: begin
            if (hit_a || any_free) begin
               rec_we = 1'b1;
               wr_key = 1'b1;
               wr_idx = hit_a ? idx_a : free_idx;
            end else begin
               result.table_full = 1'b1;
            end
         end
         ACTION_EXECUTE: begin
            if (hit_a) begin
               result.matched_function = f_ext[2:0];
               act_we = 1'b1;
               if (ret_sel) begin
                  // Leave: drop one pending return, free the record when used up.
                  result.event_res = EVENT_LEAVE;
                  act_in   = 1'b0;
                  rec_we   = 1'b1;
                  wr_idx   = idx_a;
                  valid_in = (cnt_rd > COUNT_W'(1));
                  count_in = cnt_rd - COUNT_W'(1);
               end else begin
                  // Enter: count the return address, or open a return record.
                  result.event_res = EVENT_ENTER;
                  result.recursive = active_ff[f_sel];
                  act_in = 1'b1;
                  if (hit_r) begin
                     rec_we   = 1'b1;
                     wr_idx   = idx_r;
                     count_in = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_W'(1);
                  end else if (any_free) begin
                     rec_we    = 1'b1;
                     wr_key    = 1'b1;
                     is_ret_in = 1'b1;
                     addr_in   = item.return_address;
                     fn_in     = f_sel;
                     count_in  = COUNT_W'(1);
                  end else begin
                     result.table_full = 1'b1;
                  end
               end
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // Control state: record valid and kind bits, function active marks.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         is_ret_ff <= '0;
         active_ff <= '0;
      end else if (fire) begin
         if (rec_we) begin
            valid_ff[wr_idx] <= valid_in;
         end
         if (rec_we && wr_key) begin
            is_ret_ff[wr_idx] <= is_ret_in;
         end
         if (act_we) begin
            active_ff[act_idx] <= act_in;
         end
      end
   end

   // Record payload: address, function and count.
   always_ff @(posedge clock) begin
      if (fire && rec_we) begin
         count_ff[wr_idx] <= count_in;
         if (wr_key) begin
            addr_ff[wr_idx] <= addr_in;
            fn_ff[wr_idx]   <= fn_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_full_only_without_free: assert property (@(posedge clock) disable iff (reset)
      fire && result.table_full |-> !any_free)
      else $error("table_full reported while a free record exists");

   a_leave_clears_active: assert property (@(posedge clock) disable iff (reset)
      fire && (result.event_res == EVENT_LEAVE) |=> !active_ff[$past(f_sel)])
      else $error("function still active after leave");

   a_enter_sets_active: assert property (@(posedge clock) disable iff (reset)
      fire && (result.event_res == EVENT_ENTER) |=> active_ff[$past(f_sel)])
      else $error("function not active after enter");

   a_written_record_valid: assert property (@(posedge clock) disable iff (reset)
      fire && rec_we && valid_in |=> valid_ff[$past(wr_idx)])
      else $error("written record not valid");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0) && (active_ff == '0))
      else $error("table not cleared by reset");
`endif

endmodule

// ===== hdl/call_return_tracker.sv =====
// ----------------------------------------------------------------------------
// Call/return tracker
// Watches executed program counters against registered function entries
// and the return addresses of active calls, reporting enter and leave.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the response side does not
// stall, and gives one response for each, in order. A request is held in
// an input register; while the output register can take it, the record
// table compares both the address and the return address against every
// record in parallel, forms the response into the output register and
// applies its record update, so the following request sees the updated
// table. A new request is taken in the same cycle as the held one moves
// on. A stalled response holds the request behind it in the input
// register, and no further request is taken. The table starts empty
// after reset and needs no clearing pass.
module call_return_tracker #(
   parameter int TABLE_ENTRIES  = 16,
   parameter int FUNCTION_SLOTS = 8
) (
   input  logic             clock,
   input  logic             reset,
   crt_req_if.sink          req,
   crt_rsp_if.source        rsp
);
   import crt_pkg::*;

   logic    req_valid_ff;
   logic    req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type result;
   logic    fire;

   // The held request is processed when the output register can take it.
   assign fire         = req_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready    = !req_valid_ff || fire;
   assign req_valid_in = (req.valid && req.ready) || (req_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp.ready);

   crt_table #(
      .TABLE_ENTRIES  (TABLE_ENTRIES),
      .FUNCTION_SLOTS (FUNCTION_SLOTS)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (req_ff),
      .result (result)
   );

   // Valid flags of the input and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the input register on a request transfer, of the output on fire.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_ff.action         <= req.action;
         req_ff.address        <= req.address;
         req_ff.return_address <= req.return_address;
         req_ff.function_slot  <= req.function_slot;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.event_res        = rsp_ff.event_res;
   assign rsp.matched_function = rsp_ff.matched_function;
   assign rsp.recursive        = rsp_ff.recursive;
   assign rsp.table_full       = rsp_ff.table_full;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Call/return tracker testbench
// Sends execute and register requests to the tracker and checks every
// response against a cycle-free model of the record table and the function
// active marks. The run covers directed corner cases, count saturation,
// random call/return traffic with random idling on both channels, and a
// full table at the end.
// ----------------------------------------------------------------------------
module tb;
   import crt_pkg::*;

   localparam int TABLE_ENTRIES  = 16;
   localparam int FUNCTION_SLOTS = 8;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int REPORT_LIMIT   = 10;

   logic clock;
   logic reset;

   crt_req_if req_ch ();
   crt_rsp_if rsp_ch ();

   call_return_tracker #(
      .TABLE_ENTRIES  (TABLE_ENTRIES),
      .FUNCTION_SLOTS (FUNCTION_SLOTS)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Model copy of the record table and the function active marks.
   logic               rec_valid     [TABLE_ENTRIES];
   logic               rec_is_return [TABLE_ENTRIES];
   logic [ADDR_W-1:0]  rec_addr      [TABLE_ENTRIES];
   logic [SLOT_W-1:0]  rec_func      [TABLE_ENTRIES];
   logic [COUNT_W-1:0] rec_count     [TABLE_ENTRIES];
   logic               fn_active     [FUNCTION_SLOTS];

   // Responses predicted for accepted requests, oldest first.
   rsp_type pending_outcomes[$];

   // Address pools that keep random traffic inside well-formed call chains.
   logic [ADDR_W-1:0] entry_pool  [6];
   logic [ADDR_W-1:0] return_pool [12];

   bit src_gaps_on;
   bit sink_stalls_on;

   int mismatches;
   int requests_sent;
   int responses_seen;
   int enter_count;
   int leave_count;
   int full_count;
   int cycle_count;

   // ------------------------------------------------------------------------
   // Model of the table
   // ------------------------------------------------------------------------

   // Index of the valid record holding the address, or -1.
   function automatic int find_record(logic [ADDR_W-1:0] addr);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (rec_valid[i] && rec_addr[i] == addr)
            return i;
      return -1;
   endfunction

   // Lowest free record index, or -1 when every record is in use.
   function automatic int find_free();
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (!rec_valid[i])
            return i;
      return -1;
   endfunction

   // Applies one request to the model table and returns its response.
   function automatic rsp_type predict_outcome(req_type item);
      rsp_type           outcome;
      int                hit;
      int                ret_hit;
      logic [SLOT_W-1:0] fn;
      outcome = '0;
      hit = find_record(item.address);
      if (item.action == ACTION_REGISTER) begin
         if (hit < 0)
            hit = find_free();
         if (hit < 0) begin
            outcome.table_full = 1'b1;
         end else begin
            rec_valid[hit]     = 1'b1;
            rec_is_return[hit] = 1'b0;
            rec_addr[hit]      = item.address;
            rec_func[hit]      = SLOT_W'(item.function_slot % FUNCTION_SLOTS);
            rec_count[hit]     = '0;
         end
      end else if (hit >= 0) begin
         fn = rec_func[hit];
         outcome.matched_function = fn;
         if (rec_is_return[hit]) begin
            // Leaving a function: the return record runs down its count.
            outcome.event_res = EVENT_LEAVE;
            fn_active[fn] = 1'b0;
            if (rec_count[hit] <= 1)
               rec_valid[hit] = 1'b0;
            else
               rec_count[hit] = rec_count[hit] - 1'b1;
         end else begin
            // Entering a function: bump or insert the return record.
            outcome.event_res = EVENT_ENTER;
            outcome.recursive = fn_active[fn];
            fn_active[fn] = 1'b1;
            ret_hit = find_record(item.return_address);
            if (ret_hit >= 0) begin
               if (rec_count[ret_hit] != COUNT_MAX)
                  rec_count[ret_hit] = rec_count[ret_hit] + 1'b1;
            end else begin
               ret_hit = find_free();
               if (ret_hit < 0) begin
                  outcome.table_full = 1'b1;
               end else begin
                  rec_valid[ret_hit]     = 1'b1;
                  rec_is_return[ret_hit] = 1'b1;
                  rec_addr[ret_hit]      = item.return_address;
                  rec_func[ret_hit]      = fn;
                  rec_count[ret_hit]     = 8'd1;
               end
            end
         end
      end
      return outcome;
   endfunction

   function automatic req_type compose_request(logic act, logic [ADDR_W-1:0] addr,
                                               logic [ADDR_W-1:0] ret,
                                               logic [SLOT_W-1:0] slot);
      req_type item;
      item.action         = act;
      item.address        = addr;
      item.return_address = ret;
      item.function_slot  = slot;
      return item;
   endfunction

   // ------------------------------------------------------------------------
   // Clock, cycle limit and response side
   // ------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_outcomes.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Response ready with random stall bursts.
   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Compares each response transfer with the oldest prediction.
   always @(posedge clock) begin : check_response
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.event_res        = rsp_ch.event_res;
         got.matched_function = rsp_ch.matched_function;
         got.recursive        = rsp_ch.recursive;
         got.table_full       = rsp_ch.table_full;
         responses_seen++;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("tb: response %0d arrived with nothing expected: event %0d fn %0d",
                        responses_seen, got.event_res, got.matched_function);
         end else begin
            want = pending_outcomes.pop_front();
            if (got.event_res !== want.event_res
                || got.matched_function !== want.matched_function
                || got.recursive !== want.recursive
                || got.table_full !== want.table_full) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"tb: response %0d mismatch: expected event %0d fn %0d rec %b ",
                            "full %b, got event %0d fn %0d rec %b full %b"},
                           responses_seen, want.event_res, want.matched_function,
                           want.recursive, want.table_full, got.event_res,
                           got.matched_function, got.recursive, got.table_full);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Drives one request, waits for its transfer and records the prediction.
   task automatic send_item(req_type item);
      rsp_type outcome;
      int      gap;
      if (src_gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid          = 1'b1;
      req_ch.action         = item.action;
      req_ch.address        = item.address;
      req_ch.return_address = item.return_address;
      req_ch.function_slot  = item.function_slot;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      outcome = predict_outcome(item);
      pending_outcomes = {pending_outcomes, outcome};
      requests_sent++;
      if (outcome.event_res == EVENT_ENTER) enter_count++;
      if (outcome.event_res == EVENT_LEAVE) leave_count++;
      if (outcome.table_full) full_count++;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Corner cases: extreme addresses, overwrite, recursion, leave and free.
   task automatic test_directed();
      send_item(compose_request(ACTION_EXECUTE, 32'h0000_0000, 32'hFFFF_FFFF, 3'd7));
      send_item(compose_request(ACTION_REGISTER, 32'hFFFF_FFFF, 32'h0000_0000, 3'd7));
      send_item(compose_request(ACTION_REGISTER, 32'h0000_0000, 32'hFFFF_FFFF, 3'd0));
      // Enter twice through the same call site: recursion and a count of two.
      send_item(compose_request(ACTION_EXECUTE, 32'hFFFF_FFFF, 32'h0000_1000, 3'd0));
      send_item(compose_request(ACTION_EXECUTE, 32'hFFFF_FFFF, 32'h0000_1000, 3'd7));
      send_item(compose_request(ACTION_EXECUTE, 32'h0000_1000, 32'h0000_0000, 3'd0));
      send_item(compose_request(ACTION_EXECUTE, 32'h0000_1000, 32'hFFFF_FFFF, 3'd7));
      send_item(compose_request(ACTION_EXECUTE, 32'h0000_1000, 32'h0000_0000, 3'd0));
      // A return address equal to an entry address only bumps that record.
      send_item(compose_request(ACTION_EXECUTE, 32'h0000_0000, 32'hFFFF_FFFF, 3'd0));
      send_item(compose_request(ACTION_EXECUTE, 32'hFFFF_FFFF, 32'h0000_2000, 3'd0));
      // Registering over a live return record turns it into an entry.
      send_item(compose_request(ACTION_REGISTER, 32'h0000_2000, 32'h0000_0000, 3'd3));
      send_item(compose_request(ACTION_EXECUTE, 32'h0000_2000, 32'hFFFF_FFFF, 3'd0));
      send_item(compose_request(ACTION_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd5));
      send_item(compose_request(ACTION_EXECUTE, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 3'd2));
      send_item(compose_request(ACTION_EXECUTE, 32'hAAAA_AAAA, 32'h5555_5555, 3'd7));
      send_item(compose_request(ACTION_EXECUTE, 32'h0000_0000, 32'h5555_5555, 3'd4));
      send_item(compose_request(ACTION_EXECUTE, 32'h0000_0000, 32'h5555_5555, 3'd1));
      send_item(compose_request(ACTION_EXECUTE, 32'h5555_5555, 32'hAAAA_AAAA, 3'd6));
      send_item(compose_request(ACTION_EXECUTE, 32'h5555_5555, 32'h0000_0000, 3'd0));
      send_item(compose_request(ACTION_EXECUTE, 32'h5555_5555, 32'h0000_0000, 3'd0));
   endtask

   // Drives one return record's count up past its maximum and back to free.
   task automatic test_count_saturation();
      send_item(compose_request(ACTION_REGISTER, 32'h8000_0000, 32'h0000_0000, 3'd2));
      repeat (257)
         send_item(compose_request(ACTION_EXECUTE, 32'h8000_0000, 32'h7FFF_FFFC, 3'd0));
      repeat (256)
         send_item(compose_request(ACTION_EXECUTE, 32'h7FFF_FFFC, 32'h8000_0000, 3'd0));
   endtask

   // Random call/return traffic over the address pools, with some noise.
   task automatic test_random_traffic(int n_items);
      req_type item;
      int      pick;
      int      live[$];
      for (int n = 0; n < n_items; n++) begin
         item = compose_request(ACTION_EXECUTE, $urandom, $urandom,
                                SLOT_W'($urandom_range(0, 7)));
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            item.action  = ACTION_REGISTER;
            item.address = entry_pool[$urandom_range(0, 5)];
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               live.delete();
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  if (rec_valid[i])
                     live = {live, i};
               if (live.size() != 0)
                  item.address = rec_addr[live[$urandom_range(0, live.size() - 1)]];
            end else if (pick < 65) begin
               item.address = entry_pool[$urandom_range(0, 5)];
            end else if (pick < 80) begin
               item.address = return_pool[$urandom_range(0, 11)];
            end
            // Calls come back through a small set of call sites.
            if (find_record(item.address) >= 0) begin
               if ($urandom_range(0, 99) < 88)
                  item.return_address = return_pool[$urandom_range(0, 11)];
               else
                  item.return_address = entry_pool[$urandom_range(0, 5)];
            end
         end
         send_item(item);
      end
   endtask

   // Fills the table with entries, then checks dropped inserts.
   task automatic test_table_full();
      int fn_idx;
      while (find_free() >= 0)
         send_item(compose_request(ACTION_REGISTER, $urandom, $urandom,
                                   SLOT_W'($urandom_range(0, 7))));
      send_item(compose_request(ACTION_REGISTER, $urandom, $urandom, 3'd6));
      fn_idx = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (rec_valid[i] && !rec_is_return[i])
            fn_idx = i;
      if (fn_idx >= 0) begin
         // Enter with a new call site: reported, but the insert is dropped.
         send_item(compose_request(ACTION_EXECUTE, rec_addr[fn_idx], $urandom, 3'd0));
         // Overwriting an existing record needs no free one.
         send_item(compose_request(ACTION_REGISTER, rec_addr[fn_idx], $urandom, 3'd1));
         send_item(compose_request(ACTION_EXECUTE, rec_addr[fn_idx], $urandom, 3'd0));
      end
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (rec_valid[i] && rec_is_return[i])
            send_item(compose_request(ACTION_EXECUTE, rec_addr[i], $urandom, 3'd0));
      send_item(compose_request(ACTION_EXECUTE, $urandom, $urandom, 3'd0));
   endtask

   // ------------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------------

   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.action         = ACTION_EXECUTE;
      req_ch.address        = '0;
      req_ch.return_address = '0;
      req_ch.function_slot  = '0;
      src_gaps_on           = 1'b1;
      sink_stalls_on        = 1'b1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         rec_valid[i]     = 1'b0;
         rec_is_return[i] = 1'b0;
         rec_addr[i]      = '0;
         rec_func[i]      = '0;
         rec_count[i]     = '0;
      end
      for (int i = 0; i < FUNCTION_SLOTS; i++)
         fn_active[i] = 1'b0;
      foreach (entry_pool[i])
         entry_pool[i] = $urandom;
      foreach (return_pool[i])
         return_pool[i] = $urandom;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_count_saturation();
      test_random_traffic(300);

      // A stretch without any idling, then each side idling alone.
      src_gaps_on    = 1'b0;
      sink_stalls_on = 1'b0;
      test_random_traffic(400);
      sink_stalls_on = 1'b1;
      test_random_traffic(300);
      src_gaps_on    = 1'b1;
      sink_stalls_on = 1'b0;
      test_random_traffic(200);

      // Final part runs at full rate on both channels.
      src_gaps_on    = 1'b0;
      sink_stalls_on = 1'b0;
      test_random_traffic(300);
      test_table_full();

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("tb: %0d requests, %0d responses checked in %0d cycles, %0d mismatches",
               requests_sent, responses_seen, cycle_count, mismatches);
      $display("tb: %0d enters, %0d leaves, %0d dropped inserts, counts taken to saturation",
               enter_count, leave_count, full_count);
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
